/* src/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants for the point projection and crop unit.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // Frame geometry
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COORD_W      = 10;
    localparam int SIZE_W       = 11;
    localparam int PIX_W        = 24;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd3;

    localparam logic [15:0] FOCAL_X_RST  = 16'd16800;
    localparam logic [15:0] FOCAL_Y_RST  = 16'd16800;
    localparam logic [15:0] CENTER_X_RST = 16'd10224;
    localparam logic [15:0] CENTER_Y_RST = 16'd7664;

    // Action codes
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PROJECT = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    typedef struct packed {
        logic        [1:0]  action;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
        logic        [7:0]  color_red;
        logic        [7:0]  color_green;
        logic        [7:0]  color_blue;
        logic        [9:0]  read_row;
        logic        [9:0]  read_col;
    } req_t;

    typedef struct packed {
        logic signed [15:0] pixel_row;
        logic signed [15:0] pixel_col;
        logic               in_frame;
        logic        [9:0]  crop_top;
        logic        [9:0]  crop_left;
        logic        [10:0] crop_height;
        logic        [10:0] crop_width;
        logic        [7:0]  read_red;
        logic        [7:0]  read_green;
        logic        [7:0]  read_blue;
        logic               read_valid;
    } rsp_t;

endpackage

/* src/ppc_ram.sv */
// ----------------------------------------------------------------------------
// ppc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/point_to_pixel_projection_crop_unit.sv */
// ----------------------------------------------------------------------------
// point_to_pixel_projection_crop_unit
// Pinhole projection of coloured points into an image store, with bounding
// box tracking and read-back of pixels inside the inclusive crop box.
// ----------------------------------------------------------------------------
// Usage
//   req channel (req_valid / req_stall / req_data): one command per transfer,
//   clear, project, read or none. rsp channel (rsp_valid / rsp_stall / rsp_data):
//   exactly one result per command, in order. Config port (cfg_we,
//   cfg_index, cfg_data) writes focal lengths and principal point; write
//   only while the unit is idle.
// Sequencing, one command at a time (req_stall high while busy):
//   project  per axis, two products on the shared multiplier, the
//            magnitude, the shared restoring divider and saturation;
//            the column then the row go through it.
//   read     decode, address, store read, result.
//   clear    the store is swept one entry a cycle.
//   other    decode, result.
// Reset: config registers return to defaults, box becomes empty, and a
//   clearing pass over all STORE_DEPTH (307200) entries zeroes the store;
//   req_stall stays high until it finishes. Config writes are taken throughout.
// Stalls: the result sits in an output register; while rsp_stall is high
//   it holds, and the next command can be taken and worked on meanwhile.
// ----------------------------------------------------------------------------
module point_to_pixel_projection_crop_unit
    import ppc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    // Sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_MUL1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_ABS    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_SAT    = 4'd7;
    localparam logic [3:0] S_ADDR   = 4'd8;
    localparam logic [3:0] S_STORE  = 4'd9;
    localparam logic [3:0] S_RDADDR = 4'd10;
    localparam logic [3:0] S_RDWAIT = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam int ACC_W = 42;   // numerator, below 2^41 in magnitude
    localparam int DSR_W = 44;   // 32*z shifted up by 16
    localparam int QUO_W = 17;   // top bit flags overflow

    // Control state
    logic [3:0]         state_reg,   state_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic               clr_rsp_reg, clr_rsp_next;
    logic               axis_reg,    axis_next;
    logic [4:0]         cnt_reg,     cnt_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Configuration
    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;

    // Bounding box
    logic [COORD_W-1:0] min_row_reg, min_row_next;
    logic [COORD_W-1:0] max_row_reg, max_row_next;
    logic [COORD_W-1:0] min_col_reg, min_col_next;
    logic [COORD_W-1:0] max_col_reg, max_col_next;
    logic               empty_reg,   empty_next;

    // Datapath
    req_t               cmd_reg,     cmd_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]   rem_reg,     rem_next;
    logic [DSR_W-1:0]   dsr_reg,     dsr_next;
    logic [QUO_W-1:0]   quo_reg,     quo_next;
    logic               neg_reg,     neg_next;
    logic signed [15:0] row_reg,     row_next;
    logic signed [15:0] col_reg,     col_next;
    logic               frame_reg,   frame_next;
    logic               rd_ok_reg,   rd_ok_next;
    rsp_t               rsp_reg,     rsp_next;

    // Shared multiplier
    logic signed [16:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [40:0] mul_prod;

    // Misc combinational
    logic [SIZE_W-1:0]  height, width;
    logic               div_ge;
    logic signed [15:0] sat_val;
    logic               rsp_load;
    logic               ram_we;
    logic [PIX_W-1:0]   ram_wdata;
    logic [PIX_W-1:0]   ram_rdata;

    assign height = empty_reg ? '0 :
        SIZE_W'(max_row_reg) - SIZE_W'(min_row_reg) + SIZE_W'(1);
    assign width  = empty_reg ? '0 :
        SIZE_W'(max_col_reg) - SIZE_W'(min_col_reg) + SIZE_W'(1);

    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mul_a = signed'({1'b0, axis_reg ? focal_y_reg : focal_x_reg});
            mul_b = axis_reg ? cmd_reg.point_y : cmd_reg.point_x;
        end
        else
        begin
            mul_a = signed'({1'b0, axis_reg ? center_y_reg : center_x_reg});
            mul_b = cmd_reg.point_z;
        end
    end
    assign mul_prod = mul_a * mul_b;

    assign div_ge = {2'b00, rem_reg} >= dsr_reg;

    // Truncated magnitude back to a saturated signed value
    always_comb
    begin
        if (!neg_reg)
        begin
            sat_val = (quo_reg > QUO_W'(32767)) ? 16'sh7FFF : signed'(quo_reg[15:0]);
        end
        else
        begin
            sat_val = (quo_reg > QUO_W'(32768)) ? 16'sh8000 : signed'(-quo_reg[15:0]);
        end
    end

    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_STORE);
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 :
        {cmd_reg.color_red, cmd_reg.color_green, cmd_reg.color_blue};

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        clr_rsp_next = clr_rsp_reg;
        axis_next    = axis_reg;
        cnt_next     = cnt_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        empty_next   = empty_reg;
        cmd_next     = cmd_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        frame_next   = frame_reg;
        rd_ok_next   = rd_ok_reg;
        rsp_next     = rsp_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = clr_rsp_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                row_next   = '0;
                col_next   = '0;
                frame_next = 1'b0;
                rd_ok_next = 1'b0;
                axis_next  = 1'b0;
                unique case (cmd_reg.action)
                    ACT_CLEAR:
                    begin
                        min_row_next = '0;
                        max_row_next = '0;
                        min_col_next = '0;
                        max_col_next = '0;
                        empty_next   = 1'b1;
                        addr_next    = '0;
                        clr_rsp_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    ACT_PROJECT:
                    begin
                        // non-positive depth reports zeros, stores nothing
                        if (!cmd_reg.point_z[23] && (cmd_reg.point_z != '0))
                        begin
                            state_next = S_MUL1;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ACT_READ:
                    begin
                        if (!empty_reg && (SIZE_W'(cmd_reg.read_row) < height)
                            && (SIZE_W'(cmd_reg.read_col) < width))
                        begin
                            rd_ok_next = 1'b1;
                            state_next = S_RDADDR;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ACT_NONE:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MUL1:
            begin
                acc_next   = ACC_W'(mul_prod);
                // divisor 32*z, aligned to quotient bit 16
                dsr_next   = DSR_W'(cmd_reg.point_z[22:0]) << 21;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = acc_reg + ACC_W'(mul_prod);
                state_next = S_ABS;
            end
            S_ABS:
            begin
                neg_next   = acc_reg[ACC_W-1];
                rem_next   = acc_reg[ACC_W-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
                cnt_next   = 5'd16;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = ACC_W'({2'b00, rem_reg} - dsr_reg);
                end
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (!axis_reg)
                begin
                    col_next   = sat_val;
                    axis_next  = 1'b1;
                    state_next = S_MUL1;
                end
                else
                begin
                    row_next   = sat_val;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                addr_next = ADDR_W'(row_reg[COORD_W-1:0]) * ADDR_W'(IMAGE_WIDTH)
                    + ADDR_W'(col_reg[COORD_W-1:0]);
                if (!row_reg[15] && (row_reg < 16'(IMAGE_HEIGHT))
                    && !col_reg[15] && (col_reg < 16'(IMAGE_WIDTH)))
                begin
                    frame_next = 1'b1;
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_STORE:
            begin
                if (empty_reg)
                begin
                    min_row_next = row_reg[COORD_W-1:0];
                    max_row_next = row_reg[COORD_W-1:0];
                    min_col_next = col_reg[COORD_W-1:0];
                    max_col_next = col_reg[COORD_W-1:0];
                    empty_next   = 1'b0;
                end
                else
                begin
                    if (row_reg[COORD_W-1:0] < min_row_reg) min_row_next = row_reg[COORD_W-1:0];
                    if (row_reg[COORD_W-1:0] > max_row_reg) max_row_next = row_reg[COORD_W-1:0];
                    if (col_reg[COORD_W-1:0] < min_col_reg) min_col_next = col_reg[COORD_W-1:0];
                    if (col_reg[COORD_W-1:0] > max_col_reg) max_col_next = col_reg[COORD_W-1:0];
                end
                state_next = S_DONE;
            end
            S_RDADDR:
            begin
                addr_next = ADDR_W'(SIZE_W'(min_row_reg) + SIZE_W'(cmd_reg.read_row))
                    * ADDR_W'(IMAGE_WIDTH)
                    + ADDR_W'(SIZE_W'(min_col_reg) + SIZE_W'(cmd_reg.read_col));
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_next.pixel_row   = row_reg;
                    rsp_next.pixel_col   = col_reg;
                    rsp_next.in_frame    = frame_reg;
                    rsp_next.crop_top    = empty_reg ? '0 : min_row_reg;
                    rsp_next.crop_left   = empty_reg ? '0 : min_col_reg;
                    rsp_next.crop_height = height;
                    rsp_next.crop_width  = width;
                    rsp_next.read_red    = rd_ok_reg ? ram_rdata[23:16] : '0;
                    rsp_next.read_green  = rd_ok_reg ? ram_rdata[15:8]  : '0;
                    rsp_next.read_blue   = rd_ok_reg ? ram_rdata[7:0]   : '0;
                    rsp_next.read_valid  = rd_ok_reg;
                    clr_rsp_next         = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: holds while stalled, reloads as the old one drains
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && rsp_stall)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            clr_rsp_reg   <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            min_row_reg   <= '0;
            max_row_reg   <= '0;
            min_col_reg   <= '0;
            max_col_reg   <= '0;
            empty_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            clr_rsp_reg   <= clr_rsp_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            empty_reg     <= empty_next;
        end
    end

    // Config registers, written any time the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_X_RST;
            focal_y_reg  <= FOCAL_Y_RST;
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOCAL_X:  focal_x_reg  <= cfg_data;
                CFG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
            endcase
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        frame_reg <= frame_next;
        rd_ok_reg <= rd_ok_next;
        rsp_reg   <= rsp_next;
    end

    ppc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (min_row_reg <= max_row_reg) && (min_col_reg <= max_col_reg))
        else $error("crop box min beyond max");

    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> frame_reg && (addr_reg < ADDR_W'(STORE_DEPTH)))
        else $error("store written for a pixel outside the frame");

    a_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.in_frame) |->
            !rsp_data.pixel_row[15] && (rsp_data.pixel_row < 16'(IMAGE_HEIGHT))
            && !rsp_data.pixel_col[15] && (rsp_data.pixel_col < 16'(IMAGE_WIDTH)))
        else $error("in_frame set for a pixel outside the frame");

    a_read_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.read_valid) |->
            (rsp_data.crop_height != '0) && (rsp_data.crop_width != '0))
        else $error("read reported valid with an empty box");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ABS) |=> (state_reg == S_DIV) && (cnt_reg == 5'd16))
        else $error("divider not started with full count");

endmodule
